FILE: design/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/srd_pkg.sv
// Package for the signed restoring divider: control flags carried along the pipeline.
// No dependencies; used by every module of the divider.
package srd_pkg;

    // Control flags that travel with each word from stage to stage.
    typedef struct packed {
        logic valid;
        logic neg_q;
        logic neg_r;
        logic zero;
    } ctrl_t;

endpackage

FILE: design/signed_restoring_divider_core.sv
// Top level of the signed restoring divider: input stage, a chain of step cells, output stage.
// Depends on srd_pkg, srd_front, srd_cell and srd_fix.
//
// Usage:
//   The input channel (in_valid, in_ready) takes one word holding dividend and
//   divisor. The output channel (out_valid, out_ready) delivers quotient,
//   remainder and zero_divisor. The quotient truncates toward zero and the
//   remainder carries the dividend's sign; the most negative value divided by
//   minus one wraps to the most negative value. A zero divisor gives zero
//   results with zero_divisor set.
//   A word passes one input stage, DATA_WIDTH cells of one shift-subtract
//   step each, and one output register on its way to out_valid.
//   Throughput is one word per cycle while the output is not stalled; each
//   cell does one step of one word.
//   When the receiver stalls, words pile up in the empty stages of the chain,
//   so in_ready stays high until every stage holds a word.
//   Reset clears all valid flags; the chain is empty and ready right after it.
module signed_restoring_divider_core #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] dividend,
    input  logic signed [DATA_WIDTH-1:0] divisor,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] quotient,
    output logic signed [DATA_WIDTH-1:0] remainder,
    output logic                         zero_divisor
);

    localparam int W = DATA_WIDTH;

    srd_pkg::ctrl_t ctrl_s [0:W];
    logic [W-1:0]   rem_s  [0:W];
    logic [W-1:0]   nq_s   [0:W];
    logic [W-1:0]   dmag_s [0:W];
    logic [W+1:0]   move;

    // A stage may load when it is empty or when the stage after it moves on.
    assign move[W+1] = ~out_valid | out_ready;
    for (genvar k = 0; k <= W; k++)
    begin : g_move
        assign move[k] = ~ctrl_s[k].valid | move[k+1];
    end

    assign in_ready = move[0];

    // Input stage.
    srd_front #(.W(W)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (move[0]),
        .in_valid (in_valid),
        .dividend (dividend),
        .divisor  (divisor),
        .ctrl_out (ctrl_s[0]),
        .rem_out  (rem_s[0]),
        .nq_out   (nq_s[0]),
        .dmag_out (dmag_s[0])
    );

    // Chain of step cells, one quotient bit per cell, most significant first.
    for (genvar k = 1; k <= W; k++)
    begin : g_cell
        srd_cell #(.W(W)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .load     (move[k]),
            .ctrl_in  (ctrl_s[k-1]),
            .rem_in   (rem_s[k-1]),
            .nq_in    (nq_s[k-1]),
            .dmag_in  (dmag_s[k-1]),
            .ctrl_out (ctrl_s[k]),
            .rem_out  (rem_s[k]),
            .nq_out   (nq_s[k]),
            .dmag_out (dmag_s[k])
        );
    end

    // Output stage.
    srd_fix #(.W(W)) u_fix (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (move[W+1]),
        .ctrl_in      (ctrl_s[W]),
        .rem_in       (rem_s[W]),
        .nq_in        (nq_s[W]),
        .valid        (out_valid),
        .quotient     (quotient),
        .remainder    (remainder),
        .zero_divisor (zero_divisor)
    );

endmodule

FILE: design/srd_front.sv
// Input stage of the divider: registers operand magnitudes and sign flags.
// Depends on srd_pkg for the control struct.
module srd_front #(
    parameter int W = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic                in_valid,
    input  logic signed [W-1:0] dividend,
    input  logic signed [W-1:0] divisor,
    output srd_pkg::ctrl_t      ctrl_out,
    output logic [W-1:0]        rem_out,
    output logic [W-1:0]        nq_out,
    output logic [W-1:0]        dmag_out
);

    srd_pkg::ctrl_t ctrl_reg;
    srd_pkg::ctrl_t ctrl_next;
    logic [W-1:0]   nmag_reg;
    logic [W-1:0]   dmag_reg;
    logic [W-1:0]   nmag_next;
    logic [W-1:0]   dmag_next;
    logic           n_neg;
    logic           d_neg;

    // Magnitudes; the most negative value maps to 2^(W-1) as unsigned.
    always_comb
    begin
        n_neg           = dividend[W-1];
        d_neg           = divisor[W-1];
        nmag_next       = n_neg ? (~dividend + 1'b1) : dividend;
        dmag_next       = d_neg ? (~divisor + 1'b1) : divisor;
        ctrl_next.valid = in_valid;
        ctrl_next.neg_q = n_neg ^ d_neg;
        ctrl_next.neg_r = n_neg;
        ctrl_next.zero  = (divisor == '0);
    end

    // Control register with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (load)
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    // Operand registers.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            nmag_reg <= nmag_next;
            dmag_reg <= dmag_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign rem_out  = '0;
    assign nq_out   = nmag_reg;
    assign dmag_out = dmag_reg;

endmodule

FILE: design/srd_cell.sv
// One restoring shift-subtract step with its pipeline register.
// Depends on srd_pkg for the control struct.
module srd_cell #(
    parameter int W = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  srd_pkg::ctrl_t ctrl_in,
    input  logic [W-1:0]   rem_in,
    input  logic [W-1:0]   nq_in,
    input  logic [W-1:0]   dmag_in,
    output srd_pkg::ctrl_t ctrl_out,
    output logic [W-1:0]   rem_out,
    output logic [W-1:0]   nq_out,
    output logic [W-1:0]   dmag_out
);

    srd_pkg::ctrl_t ctrl_reg;
    logic [W-1:0]   rem_reg;
    logic [W-1:0]   nq_reg;
    logic [W-1:0]   dmag_reg;
    logic [W-1:0]   rem_next;
    logic [W-1:0]   nq_next;
    logic [W-1:0]   trial;
    logic [W:0]     diff;
    logic           fits;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    // The dividend bits leave nq at the top while quotient bits enter at the bottom.
    always_comb
    begin
        trial    = {rem_in[W-2:0], nq_in[W-1]};
        diff     = {1'b0, trial} - {1'b0, dmag_in};
        fits     = ~diff[W];
        rem_next = fits ? diff[W-1:0] : trial;
        nq_next  = {nq_in[W-2:0], fits};
    end

    // Control register with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (load)
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    // Data registers.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg  <= rem_next;
            nq_reg   <= nq_next;
            dmag_reg <= dmag_in;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign rem_out  = rem_reg;
    assign nq_out   = nq_reg;
    assign dmag_out = dmag_reg;

endmodule

FILE: design/srd_fix.sv
// Output stage of the divider: applies signs, handles a zero divisor, holds the result word.
// Depends on srd_pkg for the control struct.
module srd_fix #(
    parameter int W = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  srd_pkg::ctrl_t      ctrl_in,
    input  logic [W-1:0]        rem_in,
    input  logic [W-1:0]        nq_in,
    output logic                valid,
    output logic signed [W-1:0] quotient,
    output logic signed [W-1:0] remainder,
    output logic                zero_divisor
);

    logic         valid_reg;
    logic [W-1:0] quo_reg;
    logic [W-1:0] rem_reg;
    logic         zero_reg;
    logic [W-1:0] quo_next;
    logic [W-1:0] rem_next;

    // Sign correction; a zero divisor forces both results to zero.
    always_comb
    begin
        quo_next = ctrl_in.neg_q ? (~nq_in + 1'b1) : nq_in;
        rem_next = ctrl_in.neg_r ? (~rem_in + 1'b1) : rem_in;
        if (ctrl_in.zero)
        begin
            quo_next = '0;
            rem_next = '0;
        end
    end

    // Output valid with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= ctrl_in.valid;
        end
    end

    // Result word.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            zero_reg <= ctrl_in.zero;
        end
    end

    assign valid        = valid_reg;
    assign quotient     = quo_reg;
    assign remainder    = rem_reg;
    assign zero_divisor = zero_reg;

endmodule

FILE: design/srd_checker.sv
// Port-level checker for the signed restoring divider, bound to the top level.
// Depends on assert_macros.svh and signed_restoring_divider_core.
`include "assert_macros.svh"

module srd_checker #(
    parameter int DATA_WIDTH = 32
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic signed [DATA_WIDTH-1:0] dividend,
    input logic signed [DATA_WIDTH-1:0] divisor,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic signed [DATA_WIDTH-1:0] quotient,
    input logic signed [DATA_WIDTH-1:0] remainder,
    input logic                         zero_divisor
);

    // A stalled input word stays offered with its operands unchanged.
    `SRD_ASSERT_NEXT(a_in_hold, in_valid && !in_ready,
        in_valid && $stable(dividend) && $stable(divisor),
        "input word changed while stalled")

    // A stalled result word stays offered.
    `SRD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid,
        "out_valid dropped while stalled")

    // A stalled result word keeps its payload.
    `SRD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
        $stable(quotient) && $stable(remainder) && $stable(zero_divisor),
        "result changed while stalled")

    // A zero divisor always yields zero quotient and remainder.
    `SRD_ASSERT_SAME(a_zero_result, out_valid && zero_divisor,
        quotient == '0 && remainder == '0, "zero divisor with nonzero result")

    // The pipeline is empty in the first cycle after reset.
    `SRD_ASSERT_SAME(a_empty_after_reset, !$past(rst_n), !out_valid && in_ready,
        "pipeline not empty after reset")

endmodule

bind signed_restoring_divider_core srd_checker #(.DATA_WIDTH(DATA_WIDTH)) u_srd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .dividend     (dividend),
    .divisor      (divisor),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .quotient     (quotient),
    .remainder    (remainder),
    .zero_divisor (zero_divisor)
);
